@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock outside reset.
`define ALCD_CHECK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition is followed by another one in the next clock.
`define ALCD_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/alcd_pkg.sv @@
// Shared types and constants of the LED chain driver.
package alcd_pkg;

  localparam int PIXELS = 64;
  localparam int CNT_W = $clog2(PIXELS + 1);
  localparam int ADDR_W = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam int WORD_W = 24;
  localparam int BITS_PER_PIXEL = 24;
  localparam int BIT_W = 5;
  localparam int TICK_W = 16;
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = 1;
  localparam int FIFO_CNT_W = 2;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_TICKS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_TICKS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LATCH_TICKS = 2'd2;

  localparam logic [7:0] SHORT_TICKS_RESET = 8'd14;
  localparam logic [7:0] LONG_TICKS_RESET = 8'd36;
  localparam logic [15:0] LATCH_TICKS_RESET = 16'd30000;

  typedef enum logic [1:0] {
    CMD_TICK         = 2'd0,
    CMD_FILL         = 2'd1,
    CMD_FILL_REFRESH = 2'd2,
    CMD_REFRESH      = 2'd3
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [CNT_W-1:0]   count;
    logic [WORD_W-1:0]  color;
  } cmd_t;

  typedef struct packed {
    logic  push;
    cmd_t  entry;
  } push_t;

  typedef struct packed {
    logic [7:0]   short_ticks;
    logic [7:0]   long_ticks;
    logic [15:0]  latch_ticks;
  } timing_t;

endpackage

@@ rtl/alcd_if.sv @@
// Handshake channels of the LED chain driver: command words in, line samples out.
interface alcd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [9:0]  count;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;

  modport source (output valid, mode, count, red, green, blue, input ready);
  modport sink (input valid, mode, count, red, green, blue, output ready);
endinterface

interface alcd_out_if;
  logic  valid;
  logic  ready;
  logic  line;
  logic  busy_res;
  logic  frame_done;
  logic  rejected;

  modport source (output valid, line, busy_res, frame_done, rejected, input ready);
  modport sink (input valid, line, busy_res, frame_done, rejected, output ready);
endinterface

@@ rtl/alcd_front.sv @@
// Front end: accept command words, clamp the count and pack the color.
module alcd_front (
  alcd_in_if.sink        cmd,
  input  logic           q_full,
  output alcd_pkg::push_t q_push
);
  import alcd_pkg::*;

  always_comb begin
    cmd.ready = !q_full;
    q_push.push = cmd.valid && !q_full;
    q_push.entry.kind = cmd_kind_t'(cmd.mode);
    // clamp to store size
    if (cmd.count > PIXELS) begin
      q_push.entry.count = CNT_W'(PIXELS);
    end else begin
      q_push.entry.count = CNT_W'(cmd.count);
    end
    q_push.entry.color = {cmd.green, cmd.red, cmd.blue};
  end

endmodule

@@ rtl/alcd_cmd_fifo.sv @@
// Short command queue between the front end and the line engine.
module alcd_cmd_fifo (
  input  logic             clk,
  input  logic             rst,
  input  alcd_pkg::push_t  q_push,
  output logic             q_full,
  output logic             q_valid,
  input  logic             q_pop,
  output alcd_pkg::cmd_t   q_head
);
  import alcd_pkg::*;
  `include "assert_macros.svh"

  cmd_t                   entries [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]  wr_ptr;
  logic [FIFO_PTR_W-1:0]  rd_ptr;
  logic [FIFO_CNT_W-1:0]  fill;
  logic                   do_push;
  logic                   do_pop;

  assign q_full = (fill == FIFO_CNT_W'(FIFO_DEPTH));
  assign q_valid = (fill != '0);
  assign q_head = entries[rd_ptr];
  assign do_push = q_push.push && !q_full;
  assign do_pop = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= q_push.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  `ALCD_CHECK(a_fifo_bound, fill <= FIFO_CNT_W'(FIFO_DEPTH), "command queue overfilled")
  `ALCD_CHECK_NEXT(a_fifo_pop_drains, do_pop && !do_push, fill == $past(fill) - 1'b1,
                   "pop did not drain the queue")

endmodule

@@ rtl/alcd_engine.sv @@
// Line engine: store, fill, bit timing, latch; one word per clock if unstalled.
module alcd_engine (
  input  logic             clk,
  input  logic             rst,
  input  alcd_pkg::timing_t timing,
  input  logic             q_valid,
  output logic             q_pop,
  input  alcd_pkg::cmd_t   q_head,
  alcd_out_if.source       res
);
  import alcd_pkg::*;
  `include "assert_macros.svh"

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_FILL,
    PH_HIGH,
    PH_LOW,
    PH_LATCH
  } phase_t;

  phase_t              phase, phase_next;
  logic [CNT_W-1:0]    pixel_index, pixel_index_next;
  logic [CNT_W-1:0]    pixels_to_send, pixels_to_send_next;
  logic [BIT_W-1:0]    bit_index, bit_index_next;
  logic [WORD_W-1:0]   shift_word, shift_word_next;
  logic [TICK_W-1:0]   tick_count, tick_count_next;
  logic                pending_refresh, pending_refresh_next;
  logic [WORD_W-1:0]   fill_color, fill_color_next;
  logic [CNT_W-1:0]    pf_addr, pf_addr_next;
  logic [WORD_W-1:0]   pix0;
  logic [WORD_W-1:0]   rdata;

  logic [WORD_W-1:0]   store [PIXELS];
  logic [PIXELS-1:0]   store_valid;
  logic                mem_we;
  logic [CNT_W-1:0]    mem_addr;

  logic                fire;
  logic                line_s, busy_s, done_s, rej_s;
  phase_t              ph_l;
  logic [CNT_W-1:0]    pi_l, pts_l;
  logic [BIT_W-1:0]    bi_l;
  logic [WORD_W-1:0]   sw_l, fc_l;
  logic [TICK_W-1:0]   tc_l;
  logic                pend_l;
  logic [CNT_W-1:0]    pf_l;

  function automatic logic [TICK_W-1:0] at_least_one(input logic [TICK_W-1:0] v);
    return (v == '0) ? TICK_W'(1) : v;
  endfunction

  function automatic logic [TICK_W-1:0] bit_ticks(input logic use_long, input timing_t t);
    return at_least_one(TICK_W'(use_long ? t.long_ticks : t.short_ticks));
  endfunction

  assign fire = q_valid && (!res.valid || res.ready);
  assign q_pop = fire;

  always_comb begin
    // load a command when idle; reject a non-tick command while busy
    rej_s = 1'b0;
    ph_l = phase;
    pi_l = pixel_index;
    pts_l = pixels_to_send;
    bi_l = bit_index;
    sw_l = shift_word;
    tc_l = tick_count;
    pend_l = pending_refresh;
    fc_l = fill_color;
    pf_l = pf_addr;
    if (q_head.kind != CMD_TICK) begin
      if (phase != PH_IDLE) begin
        rej_s = 1'b1;
      end else if (q_head.kind == CMD_REFRESH ||
                   (q_head.kind == CMD_FILL_REFRESH && q_head.count == '0)) begin
        pts_l = q_head.count;
        pend_l = 1'b0;
        pi_l = '0;
        bi_l = '0;
        if (q_head.count == '0) begin
          ph_l = PH_LATCH;
          tc_l = at_least_one(timing.latch_ticks);
        end else begin
          sw_l = pix0;
          ph_l = PH_HIGH;
          tc_l = bit_ticks(pix0[WORD_W-1], timing);
          pf_l = CNT_W'(1);
        end
      end else if (q_head.count != '0) begin
        fc_l = q_head.color;
        pi_l = '0;
        pts_l = q_head.count;
        pend_l = (q_head.kind == CMD_FILL_REFRESH);
        ph_l = PH_FILL;
      end
    end

    line_s = (ph_l == PH_HIGH);
    busy_s = (ph_l != PH_IDLE);
    done_s = 1'b0;
    mem_we = 1'b0;
    mem_addr = pi_l;

    phase_next = ph_l;
    pixel_index_next = pi_l;
    pixels_to_send_next = pts_l;
    bit_index_next = bi_l;
    shift_word_next = sw_l;
    tick_count_next = tc_l;
    pending_refresh_next = pend_l;
    fill_color_next = fc_l;
    pf_addr_next = pf_l;

    unique case (ph_l)
      PH_FILL: begin
        mem_we = 1'b1;
        pixel_index_next = pi_l + 1'b1;
        if (pixel_index_next >= pts_l) begin
          if (pend_l) begin
            // pixel 0 now holds the fill color
            pending_refresh_next = 1'b0;
            pixel_index_next = '0;
            bit_index_next = '0;
            shift_word_next = fc_l;
            phase_next = PH_HIGH;
            tick_count_next = bit_ticks(fc_l[WORD_W-1], timing);
            pf_addr_next = CNT_W'(1);
          end else begin
            phase_next = PH_IDLE;
          end
        end
      end
      PH_HIGH: begin
        tick_count_next = tc_l - 1'b1;
        if (tick_count_next == '0) begin
          phase_next = PH_LOW;
          tick_count_next = bit_ticks(!sw_l[WORD_W-1], timing);
        end
      end
      PH_LOW: begin
        tick_count_next = tc_l - 1'b1;
        if (tick_count_next == '0) begin
          shift_word_next = {sw_l[WORD_W-2:0], 1'b0};
          bit_index_next = bi_l + 1'b1;
          phase_next = PH_HIGH;
          if (bit_index_next == BIT_W'(BITS_PER_PIXEL)) begin
            bit_index_next = '0;
            pixel_index_next = pi_l + 1'b1;
            if (pixel_index_next >= pts_l) begin
              phase_next = PH_LATCH;
            end else begin
              // prefetched word of the next pixel
              shift_word_next = rdata;
              pf_addr_next = pixel_index_next + 1'b1;
            end
          end
          if (phase_next == PH_LATCH) begin
            tick_count_next = at_least_one(timing.latch_ticks);
          end else begin
            tick_count_next = bit_ticks(shift_word_next[WORD_W-1], timing);
          end
        end
      end
      PH_LATCH: begin
        tick_count_next = tc_l - 1'b1;
        if (tick_count_next == '0) begin
          phase_next = PH_IDLE;
          done_s = 1'b1;
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (fire && mem_we) begin
      store[mem_addr[ADDR_W-1:0]] <= fill_color_next;
    end
  end

  // registered read port of the store; unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (pf_addr < CNT_W'(PIXELS) && store_valid[pf_addr[ADDR_W-1:0]]) begin
      rdata <= store[pf_addr[ADDR_W-1:0]];
    end else begin
      rdata <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      pixel_index <= '0;
      pixels_to_send <= '0;
      bit_index <= '0;
      shift_word <= '0;
      tick_count <= '0;
      pending_refresh <= 1'b0;
      fill_color <= '0;
      pf_addr <= '0;
      pix0 <= '0;
      store_valid <= '0;
      res.valid <= 1'b0;
      res.line <= 1'b0;
      res.busy_res <= 1'b0;
      res.frame_done <= 1'b0;
      res.rejected <= 1'b0;
    end else begin
      if (res.valid && res.ready && !fire) begin
        res.valid <= 1'b0;
      end
      if (fire) begin
        phase <= phase_next;
        pixel_index <= pixel_index_next;
        pixels_to_send <= pixels_to_send_next;
        bit_index <= bit_index_next;
        shift_word <= shift_word_next;
        tick_count <= tick_count_next;
        pending_refresh <= pending_refresh_next;
        fill_color <= fill_color_next;
        pf_addr <= pf_addr_next;
        if (mem_we) begin
          store_valid[mem_addr[ADDR_W-1:0]] <= 1'b1;
          if (mem_addr == '0) begin
            pix0 <= fill_color_next;
          end
        end
        res.valid <= 1'b1;
        res.line <= line_s;
        res.busy_res <= busy_s;
        res.frame_done <= done_s;
        res.rejected <= rej_s;
      end
    end
  end

  `ALCD_CHECK(a_done_while_busy, !(res.valid && res.frame_done) || res.busy_res,
              "frame end reported outside busy")
  `ALCD_CHECK(a_reject_while_busy, !(res.valid && res.rejected) || res.busy_res,
              "rejected word reported while idle")
  `ALCD_CHECK(a_index_in_range, pixel_index <= pixels_to_send || phase == PH_IDLE,
              "pixel index ran past the frame")

endmodule

@@ rtl/addressable_led_chain_driver.sv @@
// Top level of the LED chain driver: timing registers, front end, queue and line engine.
// Path: a command word is registered in the queue, then in the output register as a result word.
// Throughput: one word per clock while a command waits and the output is not stalled; every word is one line sample.
// Bit timing runs from the next-pixel prefetch on the store's single read port.
// Reset: synchronous; the store reads as zero through per-pixel valid bits, no clearing pass.
module addressable_led_chain_driver (
  input  logic                             clk,
  input  logic                             rst,
  alcd_in_if.sink                          cmd,
  alcd_out_if.source                       res,
  input  logic                             cfg_we,
  input  logic [alcd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [alcd_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import alcd_pkg::*;

  timing_t  timing;
  push_t    q_push;
  logic     q_full;
  logic     q_valid;
  logic     q_pop;
  cmd_t     q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      timing.short_ticks <= SHORT_TICKS_RESET;
      timing.long_ticks <= LONG_TICKS_RESET;
      timing.latch_ticks <= LATCH_TICKS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SHORT_TICKS: timing.short_ticks <= cfg_data[7:0];
        REG_LONG_TICKS:  timing.long_ticks <= cfg_data[7:0];
        REG_LATCH_TICKS: timing.latch_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  alcd_front u_front (
    .cmd    (cmd),
    .q_full (q_full),
    .q_push (q_push)
  );

  alcd_cmd_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .q_push  (q_push),
    .q_full  (q_full),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .q_head  (q_head)
  );

  alcd_engine u_engine (
    .clk     (clk),
    .rst     (rst),
    .timing  (timing),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .q_head  (q_head),
    .res     (res)
  );

endmodule
